// ----- hdl/assert_macros.svh -----
// assertion macros for the rtl files, included by deq_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

// ----- hdl/deq_pkg.sv -----
// package with the deque's constants, codes and result type
package deq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WORD_W    = 32;

    // operation codes
    localparam logic [1:0] FN_INS_FRONT = 2'd0;
    localparam logic [1:0] FN_INS_REAR  = 2'd1;
    localparam logic [1:0] FN_DEL_FRONT = 2'd2;
    localparam logic [1:0] FN_DEL_REAR  = 2'd3;

    // status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_NOFRT = 2'd3;

    typedef struct packed {
        logic       strobe;
        logic       take_data;
        logic [1:0] status;
    } deq_res_t;

endpackage

// ----- hdl/deq_ram.sv -----
// generic single-port-write ram with a registered read port
module deq_ram #(
    parameter int WIDTH = deq_pkg::WORD_W,
    parameter int DEPTH = deq_pkg::DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/deq_ctrl.sv -----
// front and rear indices, operation decode and the result register
`include "assert_macros.svh"

module deq_ctrl #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int IW   = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [1:0]        func,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic              rd_en,
    output logic [AW-1:0]     rd_addr,
    output deq_pkg::deq_res_t res
);

    localparam logic [IW-1:0] TOP_IDX = IW'(DEPTH);

    logic [IW-1:0]     front_reg, front_next;
    logic [IW-1:0]     rear_reg, rear_next;
    logic [IW-1:0]     wr_idx, rd_idx;
    logic              empty;
    logic [1:0]        status_next;
    logic              take_next;
    deq_pkg::deq_res_t res_reg, res_next;

    assign empty = (front_reg >= rear_reg);

    always_comb
    begin
        front_next  = front_reg;
        rear_next   = rear_reg;
        wr_en       = 1'b0;
        wr_idx      = rear_reg;
        rd_en       = 1'b0;
        rd_idx      = front_reg;
        status_next = deq_pkg::ST_DONE;
        take_next   = 1'b0;
        if (accept)
        begin
            unique case (func)
                deq_pkg::FN_INS_FRONT:
                begin
                    if (front_reg == '0 && rear_reg == TOP_IDX)
                    begin
                        status_next = deq_pkg::ST_FULL;
                    end
                    else if (empty)
                    begin
                        // empty queue: the word goes in behind the rear
                        if (rear_reg == TOP_IDX)
                        begin
                            status_next = deq_pkg::ST_FULL;
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            wr_idx    = rear_reg;
                            rear_next = rear_reg + 1'b1;
                        end
                    end
                    else if (front_reg != '0)
                    begin
                        wr_en      = 1'b1;
                        wr_idx     = front_reg - 1'b1;
                        front_next = front_reg - 1'b1;
                    end
                    else
                    begin
                        status_next = deq_pkg::ST_NOFRT;
                    end
                end
                deq_pkg::FN_INS_REAR:
                begin
                    if (rear_reg == TOP_IDX)
                    begin
                        status_next = deq_pkg::ST_FULL;
                    end
                    else
                    begin
                        wr_en     = 1'b1;
                        wr_idx    = rear_reg;
                        rear_next = rear_reg + 1'b1;
                    end
                end
                deq_pkg::FN_DEL_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = deq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_idx     = front_reg;
                        take_next  = 1'b1;
                        front_next = front_reg + 1'b1;
                    end
                end
                deq_pkg::FN_DEL_REAR:
                begin
                    if (empty)
                    begin
                        status_next = deq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        rd_en     = 1'b1;
                        rd_idx    = rear_reg - 1'b1;
                        take_next = 1'b1;
                        rear_next = rear_reg - 1'b1;
                    end
                end
            endcase
        end
    end

    assign wr_addr = wr_idx[AW-1:0];
    assign rd_addr = rd_idx[AW-1:0];

    always_comb
    begin
        res_next.strobe    = accept;
        res_next.take_data = take_next;
        res_next.status    = status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
            res_reg   <= '0;
        end
        else
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
            res_reg   <= res_next;
        end
    end

    assign res = res_reg;

    `ASSERT_IMPL(a_index_order, clk, rst_n, 1'b1, front_reg <= rear_reg)
    `ASSERT_IMPL(a_rear_bound, clk, rst_n, 1'b1, rear_reg <= TOP_IDX)
    `ASSERT_IMPL(a_write_in_range, clk, rst_n, wr_en, wr_idx < TOP_IDX)
    `ASSERT_IMPL(a_no_rd_and_wr, clk, rst_n, wr_en, !rd_en && status_next == deq_pkg::ST_DONE)
    `ASSERT_NEXT(a_data_has_status, clk, rst_n, rd_en, res.take_data && res.status == deq_pkg::ST_DONE)

endmodule

// ----- hdl/array_double_ended_queue_top.sv -----
// top level of the linear-array deque
//
// A deque of signed 32-bit words in a linear array of DEPTH slots. An item
// (func, item_value) is taken on any clock edge with start high; busy never
// rises, so one item can enter every cycle. Its result appears on
// removed_value and status in the cycle after the item is taken, with
// done high for that single cycle; the receiver cannot stall, so it must
// take the result in that cycle. The result comes from the registered
// status and the registered read port of the slot memory. Slots are not cleared at reset.
module array_double_ended_queue_top #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          func,
    input  logic signed [deq_pkg::WORD_W-1:0]   item_value,
    output logic                                done,
    output logic signed [deq_pkg::WORD_W-1:0]   removed_value,
    output logic [1:0]                          status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                        accept;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [deq_pkg::WORD_W-1:0]  rd_data;
    deq_pkg::deq_res_t           res;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    deq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .func    (func),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .res     (res)
    );

    deq_ram #(
        .WIDTH (deq_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (item_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // inserts and failed deletes report a zero word
    assign removed_value = res.take_data ? $signed(rd_data) : '0;
    assign status        = res.status;
    assign done          = res.strobe;

endmodule
